FILE: rtl/bss_pkg.sv
// Shared types and constants for the byte substring search block.
// Used by bss_front, bss_fifo, bss_back and byte_substring_search.
package bss_pkg;

    localparam int MAX_NEEDLE   = 16;
    localparam int MAX_HAYSTACK = 65536;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 5;
    localparam int POS_W   = 17;
    localparam int OFFS_W  = 16;
    localparam int WIN_AW  = $clog2(MAX_NEEDLE);
    localparam int CFG_W   = 64;
    localparam int CIDX_W  = 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // register indexes on the configuration channel
    localparam logic [CIDX_W-1:0] REG_NEEDLE_LEN  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_NEEDLE_LOW  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_NEEDLE_HIGH = 2'd2;

    typedef logic [MAX_NEEDLE-1:0][BYTE_W-1:0] window_t;

    // one classified byte handed from front to back
    typedef struct packed {
        window_t            window;
        logic [POS_W-1:0]   pos;
        logic               last;
    } entry_t;

    typedef struct packed {
        logic [LEN_W-1:0]   len;
        window_t            needle;
    } needle_cfg_t;

endpackage

FILE: rtl/bss_front.sv
// Front end: accepts haystack bytes, shifts the recent-byte window and
// tracks the byte position of the current search. Depends on bss_pkg.
module bss_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [bss_pkg::BYTE_W-1:0]   in_byte,
    input  logic                         in_last,
    output logic                         push,
    output bss_pkg::entry_t              push_data,
    input  logic                         fifo_full
);

    bss_pkg::window_t               window_reg;
    bss_pkg::window_t               window_next;
    logic [bss_pkg::POS_W-1:0]      pos_reg;
    logic [bss_pkg::POS_W-1:0]      pos_next;
    logic                           accept;

    assign in_ready = !fifo_full;
    assign accept   = in_valid && !fifo_full;
    assign push     = accept;

    always_comb
    begin
        // entry 0 is the newest byte
        window_next = {window_reg[bss_pkg::MAX_NEEDLE-2:0], in_byte};
        pos_next    = pos_reg;
        if (pos_reg < bss_pkg::POS_W'(bss_pkg::MAX_HAYSTACK))
        begin
            pos_next = pos_reg + bss_pkg::POS_W'(1);
        end
        push_data.window = window_next;
        push_data.pos    = pos_reg;
        push_data.last   = in_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            pos_reg    <= '0;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                // start a fresh search
                window_reg <= '0;
                pos_reg    <= '0;
            end
            else
            begin
                window_reg <= window_next;
                pos_reg    <= pos_next;
            end
        end
    end

endmodule

FILE: rtl/bss_fifo.sv
// Short queue of classified bytes between front and back.
// Depends on bss_pkg for the entry type and depth.
module bss_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bss_pkg::entry_t    push_data,
    output logic               full,
    input  logic               pop,
    output bss_pkg::entry_t    head_data,
    output logic               empty
);

    bss_pkg::entry_t                  mem [bss_pkg::FIFO_DEPTH];
    logic [bss_pkg::FIFO_AW-1:0]      wr_ptr_reg;
    logic [bss_pkg::FIFO_AW-1:0]      rd_ptr_reg;
    logic [bss_pkg::FIFO_AW:0]        count_reg;
    logic                             do_push;
    logic                             do_pop;

    assign full      = (count_reg == (bss_pkg::FIFO_AW+1)'(bss_pkg::FIFO_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + bss_pkg::FIFO_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + bss_pkg::FIFO_AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (bss_pkg::FIFO_AW+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (bss_pkg::FIFO_AW+1)'(1);
            end
        end
    end

endmodule

FILE: rtl/bss_back.sv
// Back end: compares each queued window with the needle, tracks whether the
// search already matched, and holds the result in an output register.
// Depends on bss_pkg.
module bss_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  bss_pkg::needle_cfg_t          cfg,
    input  logic                          head_valid,
    input  bss_pkg::entry_t               head_data,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_found,
    output logic [bss_pkg::OFFS_W-1:0]    out_offset
);

    logic                             done_reg;
    logic                             valid_reg;
    logic                             found_reg;
    logic [bss_pkg::OFFS_W-1:0]       offset_reg;

    logic                             len_ok;
    logic                             pos_ok;
    logic                             reach_ok;
    logic [bss_pkg::MAX_NEEDLE-1:0]   byte_ok;
    logic                             hit;
    logic                             emit;
    logic [bss_pkg::WIN_AW-1:0]       win_idx [bss_pkg::MAX_NEEDLE];
    logic [bss_pkg::POS_W:0]          pos_plus1;

    assign pop = head_valid && (!valid_reg || out_ready);

    always_comb
    begin
        len_ok    = (cfg.len != '0) &&
                    (cfg.len <= bss_pkg::LEN_W'(bss_pkg::MAX_NEEDLE));
        pos_ok    = head_data.pos < bss_pkg::POS_W'(bss_pkg::MAX_HAYSTACK);
        pos_plus1 = {1'b0, head_data.pos} + (bss_pkg::POS_W+1)'(1);
        reach_ok  = pos_plus1 >= (bss_pkg::POS_W+1)'(cfg.len);
        for (int i = 0; i < bss_pkg::MAX_NEEDLE; i++)
        begin
            // needle byte i lines up with window entry len-1-i
            win_idx[i] = bss_pkg::WIN_AW'(cfg.len - bss_pkg::LEN_W'(1)
                                          - bss_pkg::LEN_W'(i));
            byte_ok[i] = (bss_pkg::LEN_W'(i) >= cfg.len) ||
                         (head_data.window[win_idx[i]] == cfg.needle[i]);
        end
        hit  = len_ok && pos_ok && reach_ok && (&byte_ok);
        emit = !done_reg && (hit || head_data.last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            // a new result replaces the one leaving in the same cycle
            if (pop && emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
            if (pop)
            begin
                if (head_data.last)
                begin
                    done_reg <= 1'b0;
                end
                else if (!done_reg && hit)
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            found_reg  <= hit;
            offset_reg <= hit ? bss_pkg::OFFS_W'(pos_plus1 - (bss_pkg::POS_W+1)'(cfg.len))
                              : '0;
        end
    end

    assign out_valid  = valid_reg;
    assign out_found  = found_reg;
    assign out_offset = offset_reg;

endmodule

FILE: rtl/byte_substring_search.sv
// Streaming first-occurrence search of a byte needle of up to 16 bytes.
// Throughput: one haystack byte per cycle while the queue has room; the back end compares
// one queued byte per cycle. A byte is queued, then compared; its result is registered.
// Stalls: a held result stops the back end; after four queued bytes s_tready drops.
// Reset: needle registers, window, position and queue clear; output is idle.
// Depends on bss_pkg, bss_front, bss_fifo and bss_back.
module byte_substring_search
(
    input  logic                        clk,
    input  logic                        rst_n,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] hay_byte
    input  logic                        s_tlast,   // last_byte
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // [15:0] match_offset
    output logic                        m_tuser,   // [0] found
    // configuration writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bss_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [bss_pkg::CFG_W-1:0]   cfg_data
);

    logic [bss_pkg::LEN_W-1:0]    needle_len_reg;
    logic [bss_pkg::CFG_W-1:0]    needle_low_reg;
    logic [bss_pkg::CFG_W-1:0]    needle_high_reg;
    bss_pkg::needle_cfg_t         cfg;

    logic                         push;
    bss_pkg::entry_t              push_data;
    logic                         fifo_full;
    logic                         fifo_empty;
    logic                         pop;
    bss_pkg::entry_t              head_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_len_reg  <= '0;
            needle_low_reg  <= '0;
            needle_high_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bss_pkg::REG_NEEDLE_LEN:  needle_len_reg  <= cfg_data[bss_pkg::LEN_W-1:0];
                bss_pkg::REG_NEEDLE_LOW:  needle_low_reg  <= cfg_data;
                bss_pkg::REG_NEEDLE_HIGH: needle_high_reg <= cfg_data;
                default:
                begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    assign cfg.len    = needle_len_reg;
    assign cfg.needle = {needle_high_reg, needle_low_reg};

    bss_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .push      (push),
        .push_data (push_data),
        .fifo_full (fifo_full)
    );

    bss_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .head_data (head_data),
        .empty     (fifo_empty)
    );

    bss_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (!fifo_empty),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_found  (m_tuser),
        .out_offset (m_tdata)
    );

endmodule

FILE: bench/testbench.sv
// Self-checking bench for byte_substring_search: a directed table, then random
// haystacks under three idle patterns, all scored on the fly.
// Depends on bss_pkg and the byte_substring_search RTL.
module testbench;

    localparam logic [bss_pkg::CIDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 16;
    localparam int SEGMENT_BYTES = 40;

    typedef struct packed {
        logic                        found;
        logic [bss_pkg::OFFS_W-1:0]  offset;
    } result_t;

    typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

    typedef struct {
        row_kind_t                   kind;
        logic [bss_pkg::CIDX_W-1:0]  index;
        logic [bss_pkg::CFG_W-1:0]   data;
        logic [7:0]                  hay;
        logic                        is_last;
        bit                          typed;
        logic                        found;
        logic [bss_pkg::OFFS_W-1:0]  offset;
    } stim_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [7:0]                   s_tdata = '0;
    logic                         s_tlast = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [15:0]                  m_tdata;
    logic                         m_tuser;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [bss_pkg::CIDX_W-1:0]   cfg_index = '0;
    logic [bss_pkg::CFG_W-1:0]    cfg_data = '0;

    int                           send_idle_pct = 35;
    int                           recv_idle_pct = 73;
    int unsigned                  mismatch_count = 0;
    result_t                      pending_results[$];
    stim_row_t                    directed_rows[$];

    // bench copy of the needle registers and search state
    logic [bss_pkg::LEN_W-1:0]    needle_len_q;
    logic [bss_pkg::CFG_W-1:0]    needle_low_q;
    logic [bss_pkg::CFG_W-1:0]    needle_high_q;
    logic [7:0]                   window_q [bss_pkg::MAX_NEEDLE];
    logic [bss_pkg::POS_W-1:0]    position_q;
    bit                           search_done_q;

    byte_substring_search dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic void clear_search();
        for (int i = 0; i < bss_pkg::MAX_NEEDLE; i++)
            window_q[i] = '0;
        position_q = '0;
        search_done_q = 1'b0;
    endfunction

    function automatic void needle_write(input logic [bss_pkg::CIDX_W-1:0] index,
                                         input logic [bss_pkg::CFG_W-1:0] data);
        case (index)
            bss_pkg::REG_NEEDLE_LEN:  needle_len_q = data[bss_pkg::LEN_W-1:0];
            bss_pkg::REG_NEEDLE_LOW:  needle_low_q = data;
            bss_pkg::REG_NEEDLE_HIGH: needle_high_q = data;
            default:                  ;
        endcase
    endfunction

    // Advance the search by one haystack byte; returns 1 when a result is due.
    function automatic bit search_step(input logic [7:0] hay, input logic is_last,
                                       output logic found,
                                       output logic [bss_pkg::OFFS_W-1:0] offset);
        logic [2*bss_pkg::CFG_W-1:0] needle;
        bit hit;
        bit emit;
        int i;
        needle = {needle_high_q, needle_low_q};
        found = 1'b0;
        offset = '0;
        hit = 1'b0;
        emit = 1'b0;
        if (!search_done_q)
        begin
            for (i = bss_pkg::MAX_NEEDLE - 1; i > 0; i--)
                window_q[i] = window_q[i-1];
            window_q[0] = hay;
            if (needle_len_q >= 1 && needle_len_q <= bss_pkg::MAX_NEEDLE
                && position_q < bss_pkg::MAX_HAYSTACK && position_q + 1 >= needle_len_q)
            begin
                hit = 1'b1;
                for (i = 0; i < needle_len_q; i++)
                    if (window_q[needle_len_q - 1 - i] != needle[8*i +: 8])
                        hit = 1'b0;
            end
            if (hit)
            begin
                found = 1'b1;
                offset = bss_pkg::OFFS_W'(position_q + 1 - needle_len_q);
                search_done_q = 1'b1;
                emit = 1'b1;
            end
            else if (is_last)
                emit = 1'b1;
            if (position_q < bss_pkg::MAX_HAYSTACK)
                position_q = position_q + 1'b1;
        end
        if (is_last)
            clear_search();
        return emit;
    endfunction

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                note_mismatch("result with none pending", 0, {m_tuser, m_tdata});
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.found)
                    note_mismatch("found", want.found, m_tuser);
                if (m_tdata !== want.offset)
                    note_mismatch("match_offset", want.offset, m_tdata);
            end
        end
    end

    // Hold cfg_valid high after the transaction; the next byte lowers it.
    task automatic cfg_write(input logic [bss_pkg::CIDX_W-1:0] index,
                             input logic [bss_pkg::CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        needle_write(index, data);
    endtask

    task automatic push_byte(input logic [7:0] hay, input logic is_last, input bit typed,
                             input logic typed_found,
                             input logic [bss_pkg::OFFS_W-1:0] typed_offset);
        logic want_found;
        logic [bss_pkg::OFFS_W-1:0] want_offset;
        bit has_result;
        cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= hay;
        s_tlast <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        has_result = search_step(hay, is_last, want_found, want_offset);
        if (typed)
            pending_results.push_back(result_t'{typed_found, typed_offset});
        else if (has_result)
            pending_results.push_back(result_t'{want_found, want_offset});
    endtask

    // Wait out every pending result, then let trailing ignored bytes flush.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void add_cfg(input logic [bss_pkg::CIDX_W-1:0] index,
                                    input logic [bss_pkg::CFG_W-1:0] data);
        directed_rows.push_back('{ROW_CFG, index, data, 8'h00, 1'b0, 1'b0, 1'b0, '0});
    endfunction

    function automatic void add_byte(input logic [7:0] hay, input logic is_last);
        directed_rows.push_back('{ROW_BYTE, '0, '0, hay, is_last, 1'b0, 1'b0, '0});
    endfunction

    function automatic void add_byte_expect(input logic [7:0] hay, input logic is_last,
                                            input logic found,
                                            input logic [bss_pkg::OFFS_W-1:0] offset);
        directed_rows.push_back('{ROW_BYTE, '0, '0, hay, is_last, 1'b1, found, offset});
    endfunction

    function automatic void build_directed();
        logic [2*bss_pkg::CFG_W-1:0] long_needle;
        long_needle = {64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF};
        // zero needle length straight out of reset
        add_byte_expect(8'h00, 1'b1, 1'b0, '0);
        add_byte_expect(8'hFF, 1'b1, 1'b0, '0);
        add_cfg(bss_pkg::REG_NEEDLE_LEN, 64'd3);
        add_cfg(bss_pkg::REG_NEEDLE_LOW, 64'hFFFF_FFFF_FF43_4241);
        add_cfg(bss_pkg::REG_NEEDLE_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        // haystack shorter than the needle
        add_byte(8'h41, 1'b0);
        add_byte_expect(8'h42, 1'b1, 1'b0, '0);
        // match on the last byte
        add_byte(8'h41, 1'b0);
        add_byte(8'h42, 1'b0);
        add_byte_expect(8'h43, 1'b1, 1'b1, 16'd0);
        // match mid-search, then the tail is ignored
        add_byte(8'h00, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'h42, 1'b0);
        add_byte_expect(8'h43, 1'b0, 1'b1, 16'd1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h41, 1'b1);
        // full 16-byte needle
        add_cfg(bss_pkg::REG_NEEDLE_LEN, 64'd16);
        add_cfg(bss_pkg::REG_NEEDLE_LOW, long_needle[63:0]);
        add_cfg(bss_pkg::REG_NEEDLE_HIGH, long_needle[127:64]);
        for (int i = 0; i < bss_pkg::MAX_NEEDLE - 1; i++)
            add_byte(long_needle[8*i +: 8], 1'b0);
        add_byte_expect(long_needle[127:120], 1'b1, 1'b1, 16'd0);
        // length above the maximum never matches; the unused index is dropped
        add_cfg(bss_pkg::REG_NEEDLE_LEN, 64'd20);
        add_cfg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        add_byte_expect(8'hEF, 1'b1, 1'b0, '0);
    endfunction

    task automatic run_directed();
        bit prev_cfg;
        prev_cfg = 1'b0;
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
            begin
                if (!prev_cfg)
                    drain_results();
                cfg_write(directed_rows[r].index, directed_rows[r].data);
                prev_cfg = 1'b1;
            end
            else
            begin
                push_byte(directed_rows[r].hay, directed_rows[r].is_last, directed_rows[r].typed,
                          directed_rows[r].found, directed_rows[r].offset);
                prev_cfg = 1'b0;
            end
        end
    endtask

    task automatic run_segment(input int seg);
        logic [2*bss_pkg::CFG_W-1:0] needle;
        logic [bss_pkg::CFG_W-1:0] len_word;
        logic [bss_pkg::LEN_W-1:0] len;
        logic [7:0] hay[$];
        int unsigned counted;
        int eff, hay_len, start, pick;
        drain_results();
        case (seg / 3)
            0:       begin send_idle_pct = 35; recv_idle_pct = 73; end
            1:       begin send_idle_pct = 73; recv_idle_pct = 35; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        endcase
        case (seg)
            1:       len = 5'd1;
            4:       len = 5'd16;
            7:       len = 5'd31;
            default:
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    len = 5'd0;
                else if (pick == 1)
                    len = bss_pkg::LEN_W'($urandom_range(17, 31));
                else if (pick == 2)
                    len = bss_pkg::LEN_W'($urandom_range(5, 16));
                else
                    len = bss_pkg::LEN_W'($urandom_range(1, 4));
            end
        endcase
        needle = {$urandom, $urandom, $urandom, $urandom};
        len_word = {$urandom, $urandom};
        len_word[bss_pkg::LEN_W-1:0] = len;
        cfg_write(bss_pkg::REG_NEEDLE_LEN, len_word);
        cfg_write(bss_pkg::REG_NEEDLE_LOW, needle[63:0]);
        cfg_write(bss_pkg::REG_NEEDLE_HIGH, needle[127:64]);
        if ($urandom_range(0, 2) == 0)
            cfg_write(REG_UNUSED, {$urandom, $urandom});
        eff = (len >= 1 && len <= bss_pkg::MAX_NEEDLE) ? int'(len) : 1;
        counted = 0;
        while (counted < SEGMENT_BYTES)
        begin
            if ($urandom_range(0, 9) == 0)
                hay_len = $urandom_range(1, eff + 36);
            else
                hay_len = $urandom_range(1, eff + 12);
            hay.delete();
            // bias bytes toward needle bytes so partial matches are common
            for (int k = 0; k < hay_len; k++)
            begin
                pick = $urandom_range(0, eff - 1);
                if ($urandom_range(0, 1))
                    hay.push_back(needle[8*pick +: 8]);
                else
                    hay.push_back(8'($urandom));
            end
            if ($urandom_range(0, 9) < 7 && hay_len >= eff)
            begin
                start = $urandom_range(0, hay_len - eff);
                for (int k = 0; k < eff; k++)
                    hay[start + k] = needle[8*k +: 8];
            end
            for (int k = 0; k < hay_len; k++)
            begin
                push_byte(hay[k], k == hay_len - 1, 1'b0, 1'b0, '0);
                counted++;
            end
        end
    endtask

    initial
    begin
        needle_len_q = '0;
        needle_low_q = '0;
        needle_high_q = '0;
        clear_search();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        build_directed();
        run_directed();
        for (int seg = 0; seg < 9; seg++)
            run_segment(seg);
        drain_results();
        if (mismatch_count == 0)
            $display("[byte_substring_search] OK");
        else
            $display("[byte_substring_search] ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("[byte_substring_search] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/bss_pkg.sv
rtl/bss_front.sv
rtl/bss_fifo.sv
rtl/bss_back.sv
rtl/byte_substring_search.sv
bench/testbench.sv
